[src/les_pkg.sv]
// Shared types, constants and codes for the Lorenz Euler step core.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package les_pkg;

   // fixed-point defaults
   localparam int FRAC_BITS_DEF  = 20;
   localparam int PLANE_SIZE_DEF = 800;
   localparam int DEFAULT_SCALE  = 15;

   // payload widths
   localparam int POS_W   = 32;
   localparam int PIX_W   = 12;
   localparam int COEF_W  = 31;
   localparam int STEP_W  = 21;
   localparam int SCALE_W = 8;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;
   localparam int WIDE_W  = 64;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SIGMA   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RHO     = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BETA    = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP    = 8'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_START_X = 8'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_START_Y = 8'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_START_Z = 8'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE   = 8'd7;

   typedef struct packed {
      logic [COEF_W-1:0]        sigma;
      logic [COEF_W-1:0]        rho;
      logic [COEF_W-1:0]        beta;
      logic [STEP_W-1:0]        step;
      logic signed [POS_W-1:0]  start_x;
      logic signed [POS_W-1:0]  start_y;
      logic signed [POS_W-1:0]  start_z;
      logic [SCALE_W-1:0]       scale;
   } cfg_type;

   typedef enum logic [2:0] {
      ALU_NOP,
      ALU_ADD,    // sat32(a + b)
      ALU_SUB,    // sat32(a - b)
      ALU_FMUL,   // sat32(floor(a * b / 2^F))
      ALU_WMUL,   // exact product into the wide register
      ALU_COL,    // column pixel from wide register
      ALU_ROW     // row pixel from wide register
   } alu_op_type;

   typedef struct packed {
      alu_op_type               op;
      logic signed [POS_W-1:0]  a;
      logic signed [POS_W-1:0]  b;
   } alu_req_type;

   typedef struct packed {
      logic signed [POS_W-1:0]  res;
      logic signed [PIX_W-1:0]  pix;
   } alu_rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_D1, ST_P1, ST_Q1, ST_X,
      ST_D2, ST_P2, ST_D3, ST_Q2, ST_Y,
      ST_P3, ST_Q3, ST_D4, ST_Q4, ST_Z,
      ST_PX, ST_PC, ST_PZ, ST_PR,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

[src/les_channels.sv]
// Valid/ready channel interfaces of the Lorenz Euler step core: step request,
// step result and register write. Depends on les_pkg for payload widths.
`timescale 1ns / 1ps
`default_nettype none

interface les_req_if
   import les_pkg::*;
   ();
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

interface les_rsp_if
   import les_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic signed [POS_W-1:0]  pos_x;
   logic signed [POS_W-1:0]  pos_y;
   logic signed [POS_W-1:0]  pos_z;
   logic signed [PIX_W-1:0]  plot_col;
   logic signed [PIX_W-1:0]  plot_row;

   modport source (output valid, output pos_x, output pos_y, output pos_z,
                   output plot_col, output plot_row, input ready);
   modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                   input plot_col, input plot_row, output ready);
endinterface

interface les_csr_if
   import les_pkg::*;
   ();
   logic                   valid;
   logic                   ready;
   logic [CSR_IDX_W-1:0]   index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[src/les_csr.sv]
// Configuration register file of the Lorenz Euler step core.
// Depends on les_pkg and the les_csr_if channel interface.
`timescale 1ns / 1ps
`default_nettype none

module les_csr
   import les_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   les_csr_if.sink     csr_chan,
   output cfg_type     cfg
);

   localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;
   localparam logic [COEF_W-1:0] SIGMA_RST = COEF_W'(64'd10 * ONE);
   localparam logic [COEF_W-1:0] RHO_RST   = COEF_W'(64'd28 * ONE);
   localparam logic [COEF_W-1:0] BETA_RST  = COEF_W'((64'd8 * ONE + 64'd1) / 64'd3);
   localparam logic [STEP_W-1:0] STEP_RST  = STEP_W'((ONE + 64'd50) / 64'd100);
   localparam logic [POS_W-1:0]  START_X_RST = POS_W'(ONE);

   cfg_type cfg_ff;
   logic    wr_en;

   assign csr_chan.ready = 1'b1;
   assign wr_en = csr_chan.valid;
   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sigma   <= SIGMA_RST;
         cfg_ff.rho     <= RHO_RST;
         cfg_ff.beta    <= BETA_RST;
         cfg_ff.step    <= STEP_RST;
         cfg_ff.start_x <= START_X_RST;
         cfg_ff.start_y <= '0;
         cfg_ff.start_z <= '0;
         cfg_ff.scale   <= SCALE_W'(DEFAULT_SCALE);
      end else if (wr_en) begin
         case (csr_chan.index)
            CSR_SIGMA:   cfg_ff.sigma   <= csr_chan.data[COEF_W-1:0];
            CSR_RHO:     cfg_ff.rho     <= csr_chan.data[COEF_W-1:0];
            CSR_BETA:    cfg_ff.beta    <= csr_chan.data[COEF_W-1:0];
            CSR_STEP:    cfg_ff.step    <= csr_chan.data[STEP_W-1:0];
            CSR_START_X: cfg_ff.start_x <= csr_chan.data[POS_W-1:0];
            CSR_START_Y: cfg_ff.start_y <= csr_chan.data[POS_W-1:0];
            CSR_START_Z: cfg_ff.start_z <= csr_chan.data[POS_W-1:0];
            CSR_SCALE:   cfg_ff.scale   <= csr_chan.data[SCALE_W-1:0];
            default: begin
               // unknown index: write dropped
            end
         endcase
      end
   end

endmodule

`default_nettype wire

[src/les_alu.sv]
// Shared arithmetic unit: saturating add/sub, fixed-point multiply and the
// pixel projection, one operation per cycle, registered results. Uses les_pkg.
`timescale 1ns / 1ps
`default_nettype none

module les_alu
   import les_pkg::*;
#(
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   parameter int PLANE_SIZE = PLANE_SIZE_DEF
) (
   input  wire logic   clock,
   input  alu_req_type alu_req,
   output alu_rsp_type alu_rsp
);

   localparam logic signed [WIDE_W-1:0] COL_BASE =
      WIDE_W'(PLANE_SIZE / 2) <<< FRAC_BITS;
   localparam logic signed [WIDE_W-1:0] ROW_BASE =
      WIDE_W'(PLANE_SIZE) <<< FRAC_BITS;
   localparam logic signed [WIDE_W-1:0] TRUNC_ADJ =
      (WIDE_W'(1) <<< FRAC_BITS) - WIDE_W'(1);
   localparam logic signed [WIDE_W-1:0] MAX32 = 64'sd2147483647;
   localparam logic signed [WIDE_W-1:0] MIN32 = -64'sd2147483648;
   localparam logic signed [WIDE_W-1:0] MAX12 = 64'sd2047;
   localparam logic signed [WIDE_W-1:0] MIN12 = -64'sd2048;

   logic signed [POS_W-1:0]   res_ff, res_in;
   logic signed [PIX_W-1:0]   pix_ff, pix_in;
   logic signed [WIDE_W-1:0]  wide_ff, wide_in;

   logic signed [POS_W:0]     sum;
   logic signed [WIDE_W-1:0]  prod;
   logic signed [WIDE_W-1:0]  shifted;
   logic signed [WIDE_W-1:0]  proj;
   logic signed [WIDE_W-1:0]  proj_t;

   always_comb begin
      res_in  = res_ff;
      pix_in  = pix_ff;
      wide_in = wide_ff;

      if (alu_req.op == ALU_SUB) begin
         sum = {alu_req.a[POS_W-1], alu_req.a} - {alu_req.b[POS_W-1], alu_req.b};
      end else begin
         sum = {alu_req.a[POS_W-1], alu_req.a} + {alu_req.b[POS_W-1], alu_req.b};
      end

      prod    = WIDE_W'(alu_req.a) * WIDE_W'(alu_req.b);
      shifted = prod >>> FRAC_BITS;   // floor

      if (alu_req.op == ALU_ROW) begin
         proj = ROW_BASE - wide_ff;
      end else begin
         proj = COL_BASE + wide_ff;
      end
      // truncate toward zero
      if (proj[WIDE_W-1]) begin
         proj_t = (proj + TRUNC_ADJ) >>> FRAC_BITS;
      end else begin
         proj_t = proj >>> FRAC_BITS;
      end

      case (alu_req.op)
         ALU_ADD, ALU_SUB: begin
            if (sum[POS_W] != sum[POS_W-1]) begin
               res_in = sum[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
            end else begin
               res_in = sum[POS_W-1:0];
            end
         end
         ALU_FMUL: begin
            if (shifted > MAX32) begin
               res_in = MAX32[POS_W-1:0];
            end else if (shifted < MIN32) begin
               res_in = MIN32[POS_W-1:0];
            end else begin
               res_in = shifted[POS_W-1:0];
            end
         end
         ALU_WMUL: begin
            wide_in = prod;
         end
         ALU_COL, ALU_ROW: begin
            if (proj_t > MAX12) begin
               pix_in = MAX12[PIX_W-1:0];
            end else if (proj_t < MIN12) begin
               pix_in = MIN12[PIX_W-1:0];
            end else begin
               pix_in = proj_t[PIX_W-1:0];
            end
         end
         default: begin
            // hold
         end
      endcase
   end

   always_ff @(posedge clock) begin
      res_ff  <= res_in;
      pix_ff  <= pix_in;
      wide_ff <= wide_in;
   end

   assign alu_rsp.res = res_ff;
   assign alu_rsp.pix = pix_ff;

endmodule

`default_nettype wire

[src/lorenz_euler_step_core.sv]
// Top level of the Lorenz Euler step core: sequencer, state registers and
// result register. Uses les_pkg, les_channels, les_csr and les_alu.
`timescale 1ns / 1ps
`default_nettype none

// Each request item advances (x, y, z) by one Euler step of the Lorenz system
// and returns one result item with the new point and its x-z pixel
// projection. A request is taken only while the sequencer is idle; a step
// runs 18 operations in sequence on one shared saturating add/multiply unit,
// and the sequencer returns to idle once the result is loaded. The result
// waits in an output register, so the next request is taken while it is
// still unclaimed; a step finishing while the previous result is still held
// waits until that one is taken. Register writes are accepted every cycle
// and must come only while idle.
module lorenz_euler_step_core
   import les_pkg::*;
#(
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   parameter int PLANE_SIZE = PLANE_SIZE_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   les_req_if.sink     req_chan,
   les_rsp_if.source   rsp_chan,
   les_csr_if.sink     csr_chan
);

   localparam logic signed [POS_W-1:0] CUR_X_RST = POS_W'(64'd1 << FRAC_BITS);

   cfg_type      cfg;
   alu_req_type  alu_req;
   alu_rsp_type  alu_rsp;

   state_type    state_ff, state_in;

   logic signed [POS_W-1:0] cur_x_ff, cur_y_ff, cur_z_ff;
   logic signed [POS_W-1:0] tmp_ff;
   logic signed [PIX_W-1:0] col_ff;

   logic                    rsp_valid_ff;
   logic signed [POS_W-1:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic signed [PIX_W-1:0] rsp_col_ff, rsp_row_ff;

   logic req_take;
   logic out_free;

   logic signed [POS_W-1:0] sg, rh, bt, dt, sc;

   les_csr #(
      .FRAC_BITS (FRAC_BITS)
   ) u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   les_alu #(
      .FRAC_BITS  (FRAC_BITS),
      .PLANE_SIZE (PLANE_SIZE)
   ) u_alu (
      .clock   (clock),
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   assign sg = POS_W'(cfg.sigma);
   assign rh = POS_W'(cfg.rho);
   assign bt = POS_W'(cfg.beta);
   assign dt = POS_W'(cfg.step);
   assign sc = POS_W'(cfg.scale);

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_take = req_chan.valid && (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in  = state_ff;
      alu_req.op = ALU_NOP;
      alu_req.a  = alu_rsp.res;
      alu_req.b  = alu_rsp.res;
      case (state_ff)
         ST_IDLE: if (req_take) state_in = ST_D1;
         ST_D1: begin
            alu_req = '{ALU_SUB, cur_y_ff, cur_x_ff};
            state_in = ST_P1;
         end
         ST_P1: begin
            alu_req = '{ALU_FMUL, sg, alu_rsp.res};
            state_in = ST_Q1;
         end
         ST_Q1: begin
            alu_req = '{ALU_FMUL, alu_rsp.res, dt};
            state_in = ST_X;
         end
         ST_X: begin
            alu_req = '{ALU_ADD, cur_x_ff, alu_rsp.res};
            state_in = ST_D2;
         end
         ST_D2: begin   // new x lands in cur_x here
            alu_req = '{ALU_SUB, rh, cur_z_ff};
            state_in = ST_P2;
         end
         ST_P2: begin
            alu_req = '{ALU_FMUL, cur_x_ff, alu_rsp.res};
            state_in = ST_D3;
         end
         ST_D3: begin
            alu_req = '{ALU_SUB, alu_rsp.res, cur_y_ff};
            state_in = ST_Q2;
         end
         ST_Q2: begin
            alu_req = '{ALU_FMUL, alu_rsp.res, dt};
            state_in = ST_Y;
         end
         ST_Y: begin
            alu_req = '{ALU_ADD, cur_y_ff, alu_rsp.res};
            state_in = ST_P3;
         end
         ST_P3: begin   // new y lands in cur_y here
            alu_req = '{ALU_FMUL, cur_x_ff, alu_rsp.res};
            state_in = ST_Q3;
         end
         ST_Q3: begin   // x*y parked in tmp
            alu_req = '{ALU_FMUL, bt, cur_z_ff};
            state_in = ST_D4;
         end
         ST_D4: begin
            alu_req = '{ALU_SUB, tmp_ff, alu_rsp.res};
            state_in = ST_Q4;
         end
         ST_Q4: begin
            alu_req = '{ALU_FMUL, alu_rsp.res, dt};
            state_in = ST_Z;
         end
         ST_Z: begin
            alu_req = '{ALU_ADD, cur_z_ff, alu_rsp.res};
            state_in = ST_PX;
         end
         ST_PX: begin   // new z lands in cur_z here
            alu_req = '{ALU_WMUL, sc, cur_x_ff};
            state_in = ST_PC;
         end
         ST_PC: begin
            alu_req.op = ALU_COL;
            state_in = ST_PZ;
         end
         ST_PZ: begin
            alu_req = '{ALU_WMUL, sc, cur_z_ff};
            state_in = ST_PR;
         end
         ST_PR: begin
            alu_req.op = ALU_ROW;
            state_in = ST_DONE;
         end
         ST_DONE: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff <= CUR_X_RST;
         cur_y_ff <= '0;
         cur_z_ff <= '0;
      end else begin
         if (req_take && req_chan.restart) begin
            cur_x_ff <= cfg.start_x;
            cur_y_ff <= cfg.start_y;
            cur_z_ff <= cfg.start_z;
         end
         if (state_ff == ST_D2) cur_x_ff <= alu_rsp.res;
         if (state_ff == ST_P3) cur_y_ff <= alu_rsp.res;
         if (state_ff == ST_PX) cur_z_ff <= alu_rsp.res;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_Q3) tmp_ff <= alu_rsp.res;
      if (state_ff == ST_PZ) col_ff <= alu_rsp.pix;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_DONE && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && out_free) begin
         rsp_x_ff   <= cur_x_ff;
         rsp_y_ff   <= cur_y_ff;
         rsp_z_ff   <= cur_z_ff;
         rsp_col_ff <= col_ff;
         rsp_row_ff <= alu_rsp.pix;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.pos_x    = rsp_x_ff;
   assign rsp_chan.pos_y    = rsp_y_ff;
   assign rsp_chan.pos_z    = rsp_z_ff;
   assign rsp_chan.plot_col = rsp_col_ff;
   assign rsp_chan.plot_row = rsp_row_ff;

`ifndef SYNTHESIS
   a_take_starts: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == ST_D1)
      else $error("taken item did not start the step sequence");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result raised outside the final step");

   a_done_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && out_free) |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("finished step not loaded into result register");
`endif

endmodule

`default_nettype wire

[tb/tb_lorenz_euler_step_core.sv]
// Self-checking bench for lorenz_euler_step_core: a directed table, then random
// step items under several register settings and handshake pacing modes.
// Depends on les_pkg, les_channels and the core RTL.
`timescale 1ns / 1ps

module tb_lorenz_euler_step_core
   import les_pkg::*;
();

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_PAD   = 25;    // longer than one full step sequence
   localparam int PHASES      = 6;
   localparam int PHASE_ITEMS = 150;
   // index past the register list, must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_NONE = 8'hFF;

   typedef logic signed [WIDE_W-1:0] wide_type;
   typedef logic signed [POS_W-1:0]  pos_type;

   localparam wide_type POS_MAX = 64'sh7FFF_FFFF;
   localparam wide_type POS_MIN = -64'sh8000_0000;

   typedef struct packed {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] z;
      logic signed [PIX_W-1:0] col;
      logic signed [PIX_W-1:0] row;
   } point_type;

   typedef enum logic [1:0] {ROW_REG, ROW_STEP, ROW_KNOWN} row_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      logic [CSR_IDX_W-1:0]   idx;
      logic [CSR_DATA_W-1:0]  data;
      logic                   restart;
      point_type              want;
   } dir_row_type;

   localparam cfg_type CFG_RESET = '{
      sigma: 31'd10485760, rho: 31'd29360128, beta: 31'd2796203, step: 21'd10486,
      start_x: 32'sd1048576, start_y: 32'sd0, start_z: 32'sd0, scale: 8'd15};

   localparam int DIR_ROWS = 49;

   // steps with step_size 0 keep the start point, so those rows are typed in
   dir_row_type dir_tab [DIR_ROWS] = '{
      '{ROW_STEP,  '0,          32'h0,         1'b0, '0},
      '{ROW_STEP,  '0,          32'h0,         1'b0, '0},
      '{ROW_STEP,  '0,          32'h0,         1'b1, '0},
      '{ROW_REG,   CSR_STEP,    32'h0,         1'b0, '0},
      '{ROW_REG,   CSR_START_X, 32'h0,         1'b0, '0},
      '{ROW_REG,   CSR_START_Y, 32'h0,         1'b0, '0},
      '{ROW_REG,   CSR_START_Z, 32'h0,         1'b0, '0},
      '{ROW_KNOWN, '0,          32'h0,         1'b1,
        '{32'sd0, 32'sd0, 32'sd0, 12'sd400, 12'sd800}},
      // coordinate extremes, widest scale: both pixels clamp low
      '{ROW_REG,   CSR_START_X, 32'h8000_0000, 1'b0, '0},
      '{ROW_REG,   CSR_START_Z, 32'h7FFF_FFFF, 1'b0, '0},
      '{ROW_REG,   CSR_SCALE,   32'hFFFF_FFFF, 1'b0, '0},
      '{ROW_KNOWN, '0,          32'h0,         1'b1,
        '{32'sh8000_0000, 32'sd0, 32'sh7FFF_FFFF, -12'sd2048, -12'sd2048}},
      '{ROW_REG,   CSR_START_X, 32'h7FFF_FFFF, 1'b0, '0},
      '{ROW_REG,   CSR_START_Y, 32'h8000_0000, 1'b0, '0},
      '{ROW_REG,   CSR_START_Z, 32'h8000_0000, 1'b0, '0},
      '{ROW_KNOWN, '0,          32'h0,         1'b1,
        '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 12'sd2047, 12'sd2047}},
      '{ROW_REG,   CSR_SCALE,   32'h0,         1'b0, '0},
      '{ROW_KNOWN, '0,          32'h0,         1'b0,
        '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 12'sd400, 12'sd800}},
      // pixel at -1.5 must truncate to -1, not floor to -2
      '{ROW_REG,   CSR_SCALE,   32'h1,         1'b0, '0},
      '{ROW_REG,   CSR_START_X, 32'hE6E8_0000, 1'b0, '0},
      '{ROW_REG,   CSR_START_Y, 32'h0,         1'b0, '0},
      '{ROW_REG,   CSR_START_Z, 32'h3218_0000, 1'b0, '0},
      '{ROW_KNOWN, '0,          32'h0,         1'b1,
        '{32'shE6E8_0000, 32'sd0, 32'sh3218_0000, -12'sd1, -12'sd1}},
      // all-ones writes: masked to register width, heavy saturation
      '{ROW_REG,   CSR_SIGMA,   32'hFFFF_FFFF, 1'b0, '0},
      '{ROW_REG,   CSR_RHO,     32'hFFFF_FFFF, 1'b0, '0},
      '{ROW_REG,   CSR_BETA,    32'hFFFF_FFFF, 1'b0, '0},
      '{ROW_REG,   CSR_STEP,    32'hFFFF_FFFF, 1'b0, '0},
      '{ROW_STEP,  '0,          32'h0,         1'b1, '0},
      '{ROW_STEP,  '0,          32'h0,         1'b0, '0},
      '{ROW_STEP,  '0,          32'h0,         1'b0, '0},
      '{ROW_REG,   CSR_SIGMA,   32'h0,         1'b0, '0},
      '{ROW_REG,   CSR_RHO,     32'h0,         1'b0, '0},
      '{ROW_REG,   CSR_BETA,    32'h0,         1'b0, '0},
      '{ROW_REG,   CSR_STEP,    32'h0010_0000, 1'b0, '0},
      '{ROW_STEP,  '0,          32'h0,         1'b0, '0},
      '{ROW_STEP,  '0,          32'h0,         1'b0, '0},
      '{ROW_REG,   CSR_NONE,    32'hFFFF_FFFF, 1'b0, '0},
      '{ROW_STEP,  '0,          32'h0,         1'b0, '0},
      '{ROW_REG,   CSR_SIGMA,   32'h00A0_0000, 1'b0, '0},
      '{ROW_REG,   CSR_RHO,     32'h01C0_0000, 1'b0, '0},
      '{ROW_REG,   CSR_BETA,    32'h002A_AAAB, 1'b0, '0},
      '{ROW_REG,   CSR_STEP,    32'h0000_28F6, 1'b0, '0},
      '{ROW_REG,   CSR_START_X, 32'h0010_0000, 1'b0, '0},
      '{ROW_REG,   CSR_START_Y, 32'h0,         1'b0, '0},
      '{ROW_REG,   CSR_START_Z, 32'h0,         1'b0, '0},
      '{ROW_REG,   CSR_SCALE,   32'd15,        1'b0, '0},
      '{ROW_STEP,  '0,          32'h0,         1'b1, '0},
      '{ROW_STEP,  '0,          32'h0,         1'b0, '0},
      '{ROW_STEP,  '0,          32'h0,         1'b0, '0}
   };

   logic clock = 1'b0;
   logic reset;

   les_req_if req_if ();
   les_rsp_if rsp_if ();
   les_csr_if csr_if ();

   lorenz_euler_step_core uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   cfg_type   cfg;
   pos_type   traj_x, traj_y, traj_z;
   point_type pending_points [$];
   int        src_idle_pct, snk_idle_pct;
   int        steps_sent, steps_checked, regs_written, bad_count, cycle_count;

   function automatic pos_type clamp32(input wide_type v);
      if (v > POS_MAX) return POS_MAX[POS_W-1:0];
      if (v < POS_MIN) return POS_MIN[POS_W-1:0];
      return v[POS_W-1:0];
   endfunction

   function automatic pos_type qsub(input pos_type a, input pos_type b);
      return clamp32(wide_type'(a) - wide_type'(b));
   endfunction

   function automatic pos_type qadd(input pos_type a, input pos_type b);
      return clamp32(wide_type'(a) + wide_type'(b));
   endfunction

   // exact product, floor shift, saturate
   function automatic pos_type qmul(input pos_type a, input pos_type b);
      return clamp32((wide_type'(a) * wide_type'(b)) >>> FRAC_BITS_DEF);
   endfunction

   // truncate toward zero, clamp to 12 bits signed
   function automatic logic signed [PIX_W-1:0] pixel(input wide_type v);
      wide_type t;
      t = (v < 0) ? -((-v) >>> FRAC_BITS_DEF) : (v >>> FRAC_BITS_DEF);
      if (t > 2047) return 12'sd2047;
      if (t < -2048) return -12'sd2048;
      return t[PIX_W-1:0];
   endfunction

   function automatic point_type lorenz_step(input bit restart);
      pos_type  sg, rh, bt, dt;
      wide_type col, row;
      sg = signed'(32'(cfg.sigma));
      rh = signed'(32'(cfg.rho));
      bt = signed'(32'(cfg.beta));
      dt = signed'(32'(cfg.step));
      if (restart) begin
         traj_x = cfg.start_x;
         traj_y = cfg.start_y;
         traj_z = cfg.start_z;
      end
      // y uses the new x, z uses the new x and y
      traj_x = qadd(traj_x, qmul(qmul(sg, qsub(traj_y, traj_x)), dt));
      traj_y = qadd(traj_y, qmul(qsub(qmul(traj_x, qsub(rh, traj_z)), traj_y), dt));
      traj_z = qadd(traj_z, qmul(qsub(qmul(traj_x, traj_y), qmul(bt, traj_z)), dt));
      col = (wide_type'(PLANE_SIZE_DEF / 2) <<< FRAC_BITS_DEF)
            + wide_type'(cfg.scale) * wide_type'(traj_x);
      row = (wide_type'(PLANE_SIZE_DEF) <<< FRAC_BITS_DEF)
            - wide_type'(cfg.scale) * wide_type'(traj_z);
      return '{traj_x, traj_y, traj_z, pixel(col), pixel(row)};
   endfunction

   // valid stays high after acceptance; an idle gap in the next call or a drain lowers it
   task automatic send_step(input bit restart, input bit typed, input point_type want);
      point_type p;
      while ($urandom_range(99) < src_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      p = lorenz_step(restart);
      if (typed) p = want;
      pending_points = {pending_points, p};
      req_if.valid   <= 1'b1;
      req_if.restart <= restart;
      do @(posedge clock); while (!req_if.ready);
      steps_sent++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_if.index <= idx;
      csr_if.data  <= val;
      csr_if.valid <= 1'b1;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      case (idx)
         CSR_SIGMA:   cfg.sigma   = val[COEF_W-1:0];
         CSR_RHO:     cfg.rho     = val[COEF_W-1:0];
         CSR_BETA:    cfg.beta    = val[COEF_W-1:0];
         CSR_STEP:    cfg.step    = val[STEP_W-1:0];
         CSR_START_X: cfg.start_x = val;
         CSR_START_Y: cfg.start_y = val;
         CSR_START_Z: cfg.start_z = val;
         CSR_SCALE:   cfg.scale   = val[SCALE_W-1:0];
         default: ;
      endcase
      regs_written++;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (DRAIN_PAD) @(posedge clock);
   endtask

   // result side: random backpressure, compare each accepted item in order
   always @(posedge clock) begin : result_check
      point_type got, want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = '{rsp_if.pos_x, rsp_if.pos_y, rsp_if.pos_z, rsp_if.plot_col, rsp_if.plot_row};
         if (pending_points.size() == 0) begin
            $display("%0t: unexpected result x=%0d y=%0d z=%0d col=%0d row=%0d",
                     $time, got.x, got.y, got.z, got.col, got.row);
            bad_count++;
         end else begin
            want = pending_points.pop_front();
            steps_checked++;
            if (got !== want) begin
               $display("%0t: mismatch expected x=%0d y=%0d z=%0d col=%0d row=%0d",
                        $time, want.x, want.y, want.z, want.col, want.row);
               $display("%0t:          actual   x=%0d y=%0d z=%0d col=%0d row=%0d",
                        $time, got.x, got.y, got.z, got.col, got.row);
               bad_count++;
            end
         end
      end
      rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_lorenz_euler_step_core NOT OK");
         $finish;
      end
   end

   initial begin : stimulus
      int p;
      int n;
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.restart <= 1'b0;
      csr_if.valid   <= 1'b0;
      csr_if.index   <= '0;
      csr_if.data    <= '0;
      cfg    = CFG_RESET;
      traj_x = CFG_RESET.start_x;
      traj_y = CFG_RESET.start_y;
      traj_z = CFG_RESET.start_z;
      src_idle_pct = 27;
      snk_idle_pct = 57;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i]) begin
         case (dir_tab[i].kind)
            ROW_REG: begin
               wait_drained();
               write_reg(dir_tab[i].idx, dir_tab[i].data);
            end
            ROW_STEP:  send_step(dir_tab[i].restart, 1'b0, '0);
            default:   send_step(dir_tab[i].restart, 1'b1, dir_tab[i].want);
         endcase
      end

      for (p = 0; p < PHASES; p++) begin
         wait_drained();
         case (p / 2)
            0: begin src_idle_pct = 27; snk_idle_pct = 57; end
            1: begin src_idle_pct = 57; snk_idle_pct = 27; end
            default: begin src_idle_pct = 0; snk_idle_pct = 0; end
         endcase
         case (p)
            1, 3: begin
               // any bit pattern, register masking included
               write_reg(CSR_SIGMA,   $urandom);
               write_reg(CSR_RHO,     $urandom);
               write_reg(CSR_BETA,    $urandom);
               write_reg(CSR_STEP,    $urandom);
               write_reg(CSR_START_X, $urandom);
               write_reg(CSR_START_Y, $urandom);
               write_reg(CSR_START_Z, $urandom);
               write_reg(CSR_SCALE,   $urandom);
            end
            2, 4: begin
               write_reg(CSR_SIGMA,   $urandom_range(32'd32 << 20));
               write_reg(CSR_RHO,     $urandom_range(32'd60 << 20));
               write_reg(CSR_BETA,    $urandom_range(32'd8 << 20));
               write_reg(CSR_STEP,    $urandom_range(52429));
               write_reg(CSR_START_X, $urandom_range(32'd80 << 20) - (32'd40 << 20));
               write_reg(CSR_START_Y, $urandom_range(32'd80 << 20) - (32'd40 << 20));
               write_reg(CSR_START_Z, $urandom_range(32'd80 << 20) - (32'd40 << 20));
               write_reg(CSR_SCALE,   $urandom_range(255));
            end
            default: begin
               // classic attractor coefficients, random start and zoom
               write_reg(CSR_SIGMA,   32'(CFG_RESET.sigma));
               write_reg(CSR_RHO,     32'(CFG_RESET.rho));
               write_reg(CSR_BETA,    32'(CFG_RESET.beta));
               write_reg(CSR_STEP,    32'(CFG_RESET.step));
               write_reg(CSR_START_X, $urandom_range(32'd40 << 20) - (32'd20 << 20));
               write_reg(CSR_START_Y, $urandom_range(32'd40 << 20) - (32'd20 << 20));
               write_reg(CSR_START_Z, $urandom_range(32'd40 << 20));
               write_reg(CSR_SCALE,   $urandom_range(1, 30));
            end
         endcase
         for (n = 0; n < PHASE_ITEMS; n++)
            send_step(n == 0 || $urandom_range(19) == 0, 1'b0, '0);
      end

      wait_drained();
      $display("Checked %0d of %0d step items; %0d register writes, %0d random settings,",
               steps_checked, steps_sent, regs_written, PHASES);
      $display("three pacing modes (sender-heavy, receiver-heavy and no idle cycles).");
      if (bad_count == 0) begin
         $display("tb_lorenz_euler_step_core OK");
      end else begin
         $display("tb_lorenz_euler_step_core NOT OK");
      end
      $finish;
   end

endmodule

[files.f]
src/les_pkg.sv
src/les_channels.sv
src/les_csr.sv
src/les_alu.sv
src/lorenz_euler_step_core.sv
tb/tb_lorenz_euler_step_core.sv
